// ----- design/lvee_pkg.sv -----
// ----------------------------------------------------------------------------
// lvee_pkg
// Shared constants for the line viewport end-point block: widths, register
// indexes, reset values, status and line class codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lvee_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int DIM_W         = 31;
  localparam int CFG_IDX_W     = 1;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 31'd52428800;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 31'd39321600;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAME = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  localparam logic [1:0] CLS_SLOPE = 2'd0;
  localparam logic [1:0] CLS_SAME  = 2'd1;
  localparam logic [1:0] CLS_VERT  = 2'd2;
  localparam logic [1:0] CLS_HORZ  = 2'd3;

endpackage

`default_nettype wire

// ----- design/lvee_if.sv -----
// ----------------------------------------------------------------------------
// lvee interfaces
// Request channels: defining points in, border points out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lvee_line_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lvee_ends_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_x;
  logic signed [31:0] first_y;
  logic signed [31:0] second_x;
  logic signed [31:0] second_y;
  logic [1:0]         status;
  modport source (output valid, first_x, first_y, second_x, second_y, status,
                  input ready);
  modport sink   (input valid, first_x, first_y, second_x, second_y, status,
                  output ready);
endinterface

`default_nettype wire

// ----- design/lvee_div_pipe.sv -----
// ----------------------------------------------------------------------------
// lvee_div_pipe
// Unsigned restoring divider, one quotient bit per register stage, with a
// sideband word that travels alongside. Whole pipe advances on en.
// ----------------------------------------------------------------------------
`default_nettype none

module lvee_div_pipe #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] side,
  output logic               out_valid,
  output logic [NW-1:0]      quo,
  output logic [SW-1:0]      side_out
);

  logic [NW-1:0] vld;
  logic [DW-1:0] rem_q  [NW];
  logic [DW-1:0] den_q  [NW];
  logic [NW-1:0] num_q  [NW];
  logic [NW-1:0] quo_q  [NW];
  logic [SW-1:0] side_q [NW];

  logic [DW-1:0] rem_next [NW];
  logic [NW-1:0] num_next [NW];
  logic [NW-1:0] quo_next [NW];

  always_comb begin
    logic [DW-1:0] r_p;
    logic [DW-1:0] d_p;
    logic [NW-1:0] n_p;
    logic [NW-1:0] q_p;
    logic [DW:0]   t;
    logic          qb;
    for (int i = 0; i < NW; i++) begin
      if (i == 0) begin
        r_p = '0;
        d_p = den;
        n_p = num;
        q_p = '0;
      end else begin
        r_p = rem_q[i-1];
        d_p = den_q[i-1];
        n_p = num_q[i-1];
        q_p = quo_q[i-1];
      end
      t = {r_p, n_p[NW-1]};
      if (t >= {1'b0, d_p}) begin
        rem_next[i] = DW'(t - {1'b0, d_p});
        qb = 1'b1;
      end else begin
        rem_next[i] = t[DW-1:0];
        qb = 1'b0;
      end
      num_next[i] = {n_p[NW-2:0], 1'b0};
      quo_next[i] = {q_p[NW-2:0], qb};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NW; i++) begin
        rem_q[i] <= rem_next[i];
        num_q[i] <= num_next[i];
        quo_q[i] <= quo_next[i];
        if (i == 0) begin
          den_q[i]  <= den;
          side_q[i] <= side;
        end else begin
          den_q[i]  <= den_q[i-1];
          side_q[i] <= side_q[i-1];
        end
      end
    end
  end

  assign out_valid = vld[NW-1];
  assign quo       = quo_q[NW-1];
  assign side_out  = side_q[NW-1];

endmodule

`default_nettype wire

// ----- design/line_viewport_extension_ends.sv -----
// ----------------------------------------------------------------------------
// line_viewport_extension_ends
// Border points of the infinite line through two points, clipped against the
// view rectangle (0,0)-(view_width,view_height), signed fixed point.
// ----------------------------------------------------------------------------
//   channel  dir  payload                                        handshake
//   line     in   start_x start_y end_x end_y                    valid/ready
//   ends     out  first_x first_y second_x second_y status       valid/ready
//   cfg      in   cfg_index cfg_data                             cfg_we
//
// One request per cycle unless ends stalls; a request runs through the slope
// divider and then the edge dividers, one quotient bit per stage.
// Synchronous reset clears valid bits and loads the default view size.
// A stall on ends freezes the whole pipe; line.ready follows it.
// ----------------------------------------------------------------------------
`default_nettype none

module line_viewport_extension_ends #(
  parameter int FRAC_BITS = lvee_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [lvee_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lvee_pkg::DIM_W-1:0]     cfg_data,
  lvee_line_if.sink                           line,
  lvee_ends_if.source                         ends
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int ZL = 66 - FRAC_BITS;
  localparam int ZT = 34 + FRAC_BITS;
  localparam int ZW = ((ZL > ZT) ? ZL : ZT) + 1;

  typedef struct packed {
    logic              kneg;
    logic [1:0]        cls;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
  } s1_side_t;

  typedef struct packed {
    logic [63:0]        pl;
    logic [63:0]        pr;
    logic               kneg;
    logic               kzero;
    logic               x1neg;
    logic               drneg;
    logic               ntneg;
    logic [1:0]         cls;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
  } s2_side_t;

  localparam int S1W = $bits(s1_side_t);
  localparam int S2W = $bits(s2_side_t);

  logic [lvee_pkg::DIM_W-1:0] view_width;
  logic [lvee_pkg::DIM_W-1:0] view_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_width  <= lvee_pkg::WIDTH_RST;
      view_height <= lvee_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lvee_pkg::REG_WIDTH:  view_width  <= cfg_data;
        lvee_pkg::REG_HEIGHT: view_height <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid;
  assign en         = !out_valid || ends.ready;
  assign line.ready = en;

  // stage A: differences, class, slope operands
  logic           a_valid;
  logic [NW-1:0]  a_num;
  logic [31:0]    a_den;
  s1_side_t       a_side;

  always_comb begin
    logic [32:0] dx;
    logic [32:0] dy;
    logic [32:0] mdx;
    logic [32:0] mdy;
    dx  = {line.end_x[31], line.end_x} - {line.start_x[31], line.start_x};
    dy  = {line.end_y[31], line.end_y} - {line.start_y[31], line.start_y};
    mdx = dx[32] ? (~dx + 33'd1) : dx;
    mdy = dy[32] ? (~dy + 33'd1) : dy;
    a_side.kneg = dx[32] ^ dy[32];
    a_side.x1   = line.start_x;
    a_side.y1   = line.start_y;
    if (dx == '0 && dy == '0) begin
      a_side.cls = lvee_pkg::CLS_SAME;
    end else if (dx == '0) begin
      a_side.cls = lvee_pkg::CLS_VERT;
    end else if (dy == '0) begin
      a_side.cls = lvee_pkg::CLS_HORZ;
    end else begin
      a_side.cls = lvee_pkg::CLS_SLOPE;
    end
    a_num = {mdy[31:0], {FRAC_BITS{1'b0}}};
    a_den = (dx == '0) ? 32'd1 : mdx[31:0];
  end

  logic          ra_valid;
  logic [NW-1:0] ra_num;
  logic [31:0]   ra_den;
  s1_side_t      ra_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      ra_valid <= 1'b0;
    end else if (en) begin
      ra_valid <= line.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ra_num  <= a_num;
      ra_den  <= a_den;
      ra_side <= a_side;
    end
  end

  logic          k_valid;
  logic [NW-1:0] k_quo;
  s1_side_t      k_side;

  lvee_div_pipe #(.NW(NW), .DW(32), .SW(S1W)) u_slope (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (ra_valid),
    .num      (ra_num),
    .den      (ra_den),
    .side     (ra_side),
    .out_valid(k_valid),
    .quo      (k_quo),
    .side_out (k_side)
  );

  // stage B: saturate slope, edge operands
  logic        b_valid;
  logic [31:0] b_kmag;
  logic        b_kneg;
  logic        b_kzero;
  logic [31:0] b_x1mag;
  logic        b_x1neg;
  logic [31:0] b_drmag;
  logic        b_drneg;
  logic [31:0] b_ntmag;
  logic        b_ntneg;
  logic [31:0] b_nbmag;
  logic        b_nbneg;
  logic [1:0]  b_cls;
  logic signed [31:0] b_x1;
  logic signed [31:0] b_y1;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= k_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [31:0] cap;
    logic [31:0] km;
    logic [32:0] x1e;
    logic [32:0] dr;
    logic [32:0] nt;
    logic [32:0] nb;
    if (en) begin
      cap = k_side.kneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      km  = (k_quo > NW'(cap)) ? cap : k_quo[31:0];
      x1e = {k_side.x1[31], k_side.x1};
      dr  = {2'b00, view_width} - x1e;
      nt  = {2'b00, view_height} - {k_side.y1[31], k_side.y1};
      nb  = 33'd0 - {k_side.y1[31], k_side.y1};
      b_kmag  <= km;
      b_kneg  <= k_side.kneg;
      b_kzero <= (km == '0);
      b_x1neg <= x1e[32];
      b_x1mag <= x1e[32] ? 32'(~x1e + 33'd1) : x1e[31:0];
      b_drneg <= dr[32];
      b_drmag <= dr[32] ? 32'(~dr + 33'd1) : dr[31:0];
      b_ntneg <= nt[32];
      b_ntmag <= nt[32] ? 32'(~nt + 33'd1) : nt[31:0];
      b_nbneg <= nb[32];
      b_nbmag <= nb[32] ? 32'(~nb + 33'd1) : nb[31:0];
      b_cls   <= k_side.cls;
      b_x1    <= k_side.x1;
      b_y1    <= k_side.y1;
    end
  end

  // stage C: edge divisions; products land in the first divider stage
  s2_side_t    c_side;
  logic [31:0] c_den;

  always_comb begin
    c_side.pl    = 64'(b_kmag) * 64'(b_x1mag);
    c_side.pr    = 64'(b_kmag) * 64'(b_drmag);
    c_side.kneg  = b_kneg;
    c_side.kzero = b_kzero;
    c_side.x1neg = b_x1neg;
    c_side.drneg = b_drneg;
    c_side.ntneg = b_ntneg;
    c_side.cls   = b_cls;
    c_side.x1    = b_x1;
    c_side.y1    = b_y1;
    c_den        = b_kzero ? 32'd1 : b_kmag;
  end

  logic          t_valid;
  logic [NW-1:0] t_quo;
  s2_side_t      t_side;
  logic          bt_valid;
  logic [NW-1:0] bt_quo;
  logic          bt_nbneg;

  lvee_div_pipe #(.NW(NW), .DW(32), .SW(S2W)) u_top (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (b_valid),
    .num      ({b_ntmag, {FRAC_BITS{1'b0}}}),
    .den      (c_den),
    .side     (c_side),
    .out_valid(t_valid),
    .quo      (t_quo),
    .side_out (t_side)
  );

  lvee_div_pipe #(.NW(NW), .DW(32), .SW(1)) u_bottom (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (b_valid),
    .num      ({b_nbmag, {FRAC_BITS{1'b0}}}),
    .den      (c_den),
    .side     (b_nbneg),
    .out_valid(bt_valid),
    .quo      (bt_quo),
    .side_out (bt_nbneg)
  );

  // stage D: edge coordinates and hit tests
  logic        d_valid;
  logic [3:0]  d_hit;
  logic [31:0] d_zl;
  logic [31:0] d_zt;
  logic [31:0] d_zr;
  logic [31:0] d_zb;
  logic [1:0]  d_cls;
  logic signed [31:0] d_x1;
  logic signed [31:0] d_y1;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= t_valid && bt_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [ZW-1:0]        ml_m;
    logic [ZW-1:0]        mr_m;
    logic [ZW-1:0]        qt_m;
    logic [ZW-1:0]        qb_m;
    logic signed [ZW-1:0] x1z;
    logic signed [ZW-1:0] y1z;
    logic signed [ZW-1:0] wz;
    logic signed [ZW-1:0] hz;
    logic signed [ZW-1:0] zl;
    logic signed [ZW-1:0] zt;
    logic signed [ZW-1:0] zr;
    logic signed [ZW-1:0] zb;
    if (en) begin
      ml_m = ZW'(t_side.pl >> FRAC_BITS);
      mr_m = ZW'(t_side.pr >> FRAC_BITS);
      qt_m = ZW'(t_quo);
      qb_m = ZW'(bt_quo);
      x1z  = ZW'(t_side.x1);
      y1z  = ZW'(t_side.y1);
      wz   = $signed(ZW'(view_width));
      hz   = $signed(ZW'(view_height));
      zl = y1z - ((t_side.kneg ^ t_side.x1neg) ? -$signed(ml_m) : $signed(ml_m));
      zt = ((t_side.kneg ^ t_side.ntneg) ? -$signed(qt_m) : $signed(qt_m)) + x1z;
      zr = ((t_side.kneg ^ t_side.drneg) ? -$signed(mr_m) : $signed(mr_m)) + y1z;
      zb = ((t_side.kneg ^ bt_nbneg) ? -$signed(qb_m) : $signed(qb_m)) + x1z;
      d_hit[0] <= (zl >= 0) && (zl < hz);
      d_hit[1] <= !t_side.kzero && (zt >= 0) && (zt < wz);
      d_hit[2] <= (zr > 0) && (zr <= hz);
      d_hit[3] <= !t_side.kzero && (zb > 0) && (zb <= wz);
      d_zl  <= zl[31:0];
      d_zt  <= zt[31:0];
      d_zr  <= zr[31:0];
      d_zb  <= zb[31:0];
      d_cls <= t_side.cls;
      d_x1  <= t_side.x1;
      d_y1  <= t_side.y1;
    end
  end

  // output register: pick the first two hits
  logic [31:0] o_fx;
  logic [31:0] o_fy;
  logic [31:0] o_sx;
  logic [31:0] o_sy;
  logic [1:0]  o_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [31:0] px [4];
    logic [31:0] py [4];
    logic [31:0] fx;
    logic [31:0] fy;
    logic [31:0] sx;
    logic [31:0] sy;
    logic [1:0]  n;
    logic [31:0] wv;
    logic [31:0] hv;
    if (en) begin
      wv = {1'b0, view_width};
      hv = {1'b0, view_height};
      px[0] = '0;   py[0] = d_zl;
      px[1] = d_zt; py[1] = hv;
      px[2] = wv;   py[2] = d_zr;
      px[3] = d_zb; py[3] = '0;
      fx = '0; fy = '0; sx = '0; sy = '0;
      n  = 2'd0;
      for (int i = 0; i < 4; i++) begin
        if (d_hit[i] && n == 2'd0) begin
          fx = px[i]; fy = py[i]; n = 2'd1;
        end else if (d_hit[i] && n == 2'd1) begin
          sx = px[i]; sy = py[i]; n = 2'd2;
        end
      end
      unique case (d_cls)
        lvee_pkg::CLS_SAME: begin
          o_fx <= '0; o_fy <= '0; o_sx <= '0; o_sy <= '0;
          o_st <= lvee_pkg::ST_SAME;
        end
        lvee_pkg::CLS_VERT: begin
          o_fx <= d_x1; o_fy <= '0; o_sx <= d_x1; o_sy <= hv;
          o_st <= lvee_pkg::ST_OK;
        end
        lvee_pkg::CLS_HORZ: begin
          o_fx <= '0; o_fy <= d_y1; o_sx <= wv; o_sy <= d_y1;
          o_st <= lvee_pkg::ST_OK;
        end
        default: begin
          if (n == 2'd2) begin
            o_fx <= fx; o_fy <= fy; o_sx <= sx; o_sy <= sy;
            o_st <= lvee_pkg::ST_OK;
          end else begin
            o_fx <= '0; o_fy <= '0; o_sx <= '0; o_sy <= '0;
            o_st <= lvee_pkg::ST_MISS;
          end
        end
      endcase
    end
  end

  assign ends.valid    = out_valid;
  assign ends.first_x  = $signed(o_fx);
  assign ends.first_y  = $signed(o_fy);
  assign ends.second_x = $signed(o_sx);
  assign ends.second_y = $signed(o_sy);
  assign ends.status   = o_st;

endmodule

`default_nettype wire
